@@ rtl/distance_vector_route_table_assert.svh @@
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define DVRT_ASSERT(lbl, prop) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) \
      else $error("route table check failed");

// Checks a property on every rising clock edge, reset included.
`define DVRT_ASSERT_ALWAYS(lbl, prop) \
   lbl: assert property (@(posedge clock) (prop)) \
      else $error("route table check failed");

`endif

@@ rtl/dvrt_pkg.sv @@
package dvrt_pkg;

   // Table geometry.
   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   // Route constants.
   localparam logic [31:0] MAX_GOOD_METRIC = 32'd15;
   localparam logic [31:0] LOOPBACK_NET    = 32'h7F00_0000;
   localparam logic [31:0] LOCAL_SOURCE    = 32'hFFFF_FFF5;
   localparam logic [4:0]  METRIC_INFINITY = 5'd16;

   typedef enum logic [1:0] {
      OP_LEARN     = 2'd0,
      OP_INSTALL   = 2'd1,
      OP_ADVERTISE = 2'd2,
      OP_UNUSED    = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_ADDED       = 3'd0,
      ST_REPLACED    = 3'd1,
      ST_KEPT        = 3'd2,
      ST_METRIC_DROP = 3'd3,
      ST_LOOP_DROP   = 3'd4,
      ST_FULL        = 3'd5,
      ST_ADVERTISED  = 3'd6,
      ST_EMPTY       = 3'd7
   } route_status_type;

   // Source of the next result word.
   typedef enum logic [2:0] {
      SEL_METRIC_DROP,
      SEL_LOOP_DROP,
      SEL_FULL,
      SEL_ADDED,
      SEL_HIT,
      SEL_PEND_MORE,
      SEL_PEND_LAST,
      SEL_EMPTY
   } out_sel_type;

   typedef struct packed {
      logic [1:0]  operation;
      logic [31:0] address;
      logic [31:0] mask;
      logic [31:0] metric;
      logic [31:0] source;
   } req_type;

   typedef struct packed {
      logic [31:0] network;
      logic [31:0] net_mask;
      logic [4:0]  hop_metric;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] network;
      logic [31:0] mask;
      logic [3:0]  metric;
      logic [31:0] source;
   } route_entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic        req_load;
      logic        rd_clear;
      logic        rd_en;
      logic        rd_consume;
      logic        pend_load;
      logic        out_load;
      out_sel_type out_sel;
      logic        wr_hit;
      logic        wr_new;
   } dvrt_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      op_type op;
      logic   drop_metric;
      logic   drop_loop;
      logic   rd_valid;
      logic   match;
      logic   qualify;
      logic   issue_more;
      logic   pend_valid;
      logic   out_free;
      logic   table_full;
      logic   hit_replace;
   } dvrt_status_type;

endpackage

@@ rtl/dvrt_datapath.sv @@
module dvrt_datapath
   import dvrt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  req_type         req_data,
   input  dvrt_cmd_type    cmd,
   input  logic            rsp_stall,
   output rsp_type         rsp_data,
   output logic            rsp_valid,
   output dvrt_status_type status
);

   route_entry_type route_mem [TABLE_DEPTH];

   req_type         req_ff;
   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] rd_idx_ff;
   logic             rd_valid_ff;
   logic             rd_valid_in;
   logic [IDX_W-1:0] rd_tag_ff;
   route_entry_type  rd_data_ff;
   rsp_type          pend_ff;
   logic             pend_valid_ff;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;

   logic            is_install;
   logic [31:0]     key;
   logic [3:0]      met4;
   logic [31:0]     src;
   logic            hit_replace;
   logic            out_free;
   route_entry_type wr_entry;
   rsp_type         result;
   rsp_type         adv_item;

   // Operands of the held request.
   assign is_install = (req_ff.operation == OP_INSTALL);
   assign key        = is_install ? (req_ff.address & req_ff.mask) : req_ff.address;
   assign met4       = is_install ? 4'd0 : req_ff.metric[3:0];
   assign src        = is_install ? LOCAL_SOURCE : req_ff.source;
   assign wr_entry   = '{network: key, mask: req_ff.mask, metric: met4, source: src};

   // A found entry is overwritten on install, a better metric or the same neighbor.
   assign hit_replace = is_install || (rd_data_ff.metric > met4) ||
                        (rd_data_ff.source == src);

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Advertised form of the entry that was just read.
   assign adv_item = '{network: rd_data_ff.network, net_mask: rd_data_ff.mask,
                       hop_metric: {1'b0, rd_data_ff.metric} + 5'd1,
                       status: ST_ADVERTISED, last: 1'b0};

   // Result word selection.
   always_comb begin
      unique case (cmd.out_sel)
         SEL_METRIC_DROP: result = '{req_ff.address, req_ff.mask, METRIC_INFINITY,
                                     ST_METRIC_DROP, 1'b1};
         SEL_LOOP_DROP:   result = '{key, req_ff.mask, {1'b0, met4}, ST_LOOP_DROP, 1'b1};
         SEL_FULL:        result = '{key, req_ff.mask, {1'b0, met4}, ST_FULL, 1'b1};
         SEL_ADDED:       result = '{key, req_ff.mask, {1'b0, met4}, ST_ADDED, 1'b1};
         SEL_HIT: begin
            if (hit_replace) begin
               result = '{key, req_ff.mask, {1'b0, met4}, ST_REPLACED, 1'b1};
            end else begin
               result = '{key, rd_data_ff.mask, {1'b0, rd_data_ff.metric}, ST_KEPT, 1'b1};
            end
         end
         SEL_PEND_MORE:   result = pend_ff;
         SEL_PEND_LAST:   result = '{pend_ff.network, pend_ff.net_mask, pend_ff.hop_metric,
                                     pend_ff.status, 1'b1};
         SEL_EMPTY:       result = '{32'd0, 32'd0, 5'd0, ST_EMPTY, 1'b1};
         default:         result = pend_ff;
      endcase
   end

   // Held request, advertisement holding slot and result register.
   always_ff @(posedge clock) begin
      if (cmd.req_load) begin
         req_ff <= req_data;
      end
      if (cmd.pend_load) begin
         pend_ff <= adv_item;
      end
      if (cmd.out_load) begin
         rsp_ff <= result;
      end
   end

   // Table storage: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.wr_hit) begin
         route_mem[rd_tag_ff] <= wr_entry;
      end else if (cmd.wr_new) begin
         route_mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= route_mem[rd_idx_ff[IDX_W-1:0]];
         rd_tag_ff  <= rd_idx_ff[IDX_W-1:0];
      end
   end

   // Read data is valid until the controller consumes it.
   always_comb begin
      rd_valid_in = rd_valid_ff;
      if (cmd.rd_clear) begin
         rd_valid_in = 1'b0;
      end else if (cmd.rd_en) begin
         rd_valid_in = 1'b1;
      end else if (cmd.rd_consume) begin
         rd_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         rd_idx_ff     <= '0;
         rd_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rd_valid_ff <= rd_valid_in;
         if (cmd.rd_clear) begin
            rd_idx_ff <= '0;
         end else if (cmd.rd_en) begin
            rd_idx_ff <= rd_idx_ff + CNT_W'(1);
         end
         if (cmd.rd_clear) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.pend_load) begin
            pend_valid_ff <= 1'b1;
         end
         if (cmd.wr_new) begin
            count_ff <= count_ff + CNT_W'(1);
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Status toward the controller.
   always_comb begin
      status.op          = op_type'(req_ff.operation);
      status.drop_metric = (req_ff.operation == OP_LEARN) &&
                           (req_ff.metric > MAX_GOOD_METRIC);
      status.drop_loop   = (key == LOOPBACK_NET);
      status.rd_valid    = rd_valid_ff;
      status.match       = (rd_data_ff.network == key);
      status.qualify     = (rd_data_ff.source != req_ff.source);
      status.issue_more  = (rd_idx_ff < count_ff);
      status.pend_valid  = pend_valid_ff;
      status.out_free    = out_free;
      status.table_full  = (count_ff >= CNT_W'(TABLE_DEPTH));
      status.hit_replace = hit_replace;
   end

   assign rsp_data  = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

`include "distance_vector_route_table_assert.svh"

   `DVRT_ASSERT(a_load_needs_room, cmd.out_load |-> out_free)
   `DVRT_ASSERT(a_single_write, !(cmd.wr_hit && cmd.wr_new))
   `DVRT_ASSERT(a_count_bound, count_ff <= CNT_W'(TABLE_DEPTH))
   `DVRT_ASSERT(a_add_grows, cmd.wr_new |=> (count_ff == $past(count_ff) + CNT_W'(1)))
   `DVRT_ASSERT_ALWAYS(a_reset_empty, reset |=> (count_ff == '0))

endmodule

@@ rtl/dvrt_ctrl.sv @@
module dvrt_ctrl
   import dvrt_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  dvrt_status_type status,
   output dvrt_cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_SEARCH,
      S_HIT,
      S_MISS,
      S_METRIC_DROP,
      S_LOOP_DROP,
      S_ADVERTISE,
      S_ADV_END
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      adv_consume;

   assign req_stall = (state_ff != S_IDLE);

   // An advertised entry can move to the holding slot unless that slot must
   // first be pushed out to a full result register.
   assign adv_consume = status.rd_valid &&
                        (!status.qualify || !status.pend_valid || status.out_free);

   // Next state and commands.
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.out_sel = SEL_EMPTY;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.req_load = 1'b1;
               state_in     = S_DECODE;
            end
         end
         S_DECODE: begin
            unique case (status.op)
               OP_UNUSED: state_in = S_IDLE;
               OP_ADVERTISE: begin
                  cmd.rd_clear = 1'b1;
                  state_in     = S_ADVERTISE;
               end
               OP_LEARN, OP_INSTALL: begin
                  priority if (status.drop_metric) begin
                     state_in = S_METRIC_DROP;
                  end else if (status.drop_loop) begin
                     state_in = S_LOOP_DROP;
                  end else begin
                     cmd.rd_clear = 1'b1;
                     state_in     = S_SEARCH;
                  end
               end
            endcase
         end
         S_SEARCH: begin
            // One read a cycle; the read data holds once it matches.
            cmd.rd_consume = status.rd_valid && !status.match;
            cmd.rd_en      = status.issue_more && !(status.rd_valid && status.match);
            if (status.rd_valid && status.match) begin
               state_in = S_HIT;
            end else if (!status.issue_more && !status.rd_valid) begin
               state_in = S_MISS;
            end
         end
         S_HIT: begin
            cmd.out_sel = SEL_HIT;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.wr_hit   = status.hit_replace;
               state_in     = S_IDLE;
            end
         end
         S_MISS: begin
            cmd.out_sel = status.table_full ? SEL_FULL : SEL_ADDED;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.wr_new   = !status.table_full;
               state_in     = S_IDLE;
            end
         end
         S_METRIC_DROP: begin
            cmd.out_sel = SEL_METRIC_DROP;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_LOOP_DROP: begin
            cmd.out_sel = SEL_LOOP_DROP;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_ADVERTISE: begin
            // A qualifying entry pushes the previous one out as a non-final result.
            cmd.out_sel    = SEL_PEND_MORE;
            cmd.rd_consume = adv_consume;
            cmd.rd_en      = status.issue_more && (!status.rd_valid || adv_consume);
            if (adv_consume && status.qualify) begin
               cmd.pend_load = 1'b1;
               cmd.out_load  = status.pend_valid;
            end
            if (!status.issue_more && !status.rd_valid) begin
               state_in = S_ADV_END;
            end
         end
         S_ADV_END: begin
            cmd.out_sel = status.pend_valid ? SEL_PEND_LAST : SEL_EMPTY;
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/distance_vector_route_table.sv @@
// Channel   Direction  Payload    Handshake
// req_      in         req_type   req_valid / req_stall
// rsp_      out        rsp_type   rsp_valid / rsp_stall
//
// One request at a time. Learn, install and advertise pass from one acceptance to the
// next through take, decode, one read per entry with the read register filled and
// drained, and loading the result. A hit ends the search early; a dropped request
// skips the search. Reset clears the route count and valid flags but not the table;
// no clearing pass is needed. While a result waits under rsp_stall with the holding
// slot full, an advertisement stops at the next qualifying entry.
module distance_vector_route_table
   import dvrt_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   dvrt_cmd_type    cmd;
   dvrt_status_type status;

   // Sequencer.
   dvrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Table, search registers and result register.
   dvrt_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .rsp_valid (rsp_valid),
      .status    (status)
   );

endmodule

@@ verif/distance_vector_route_table_test.sv @@
module distance_vector_route_table_test;
   import dvrt_pkg::*;

   localparam logic [31:0] NEIGHBOR_A     = 32'h0A00_0001;
   localparam logic [31:0] NEIGHBOR_B     = 32'h0A00_0002;
   localparam logic [31:0] NEIGHBOR_C     = 32'hAC10_0001;
   localparam int          ITEMS_PER_MODE = 30;
   localparam int          STUCK_LIMIT    = 2000;
   localparam int          DRAIN_CYCLES   = 100;

   // One directed request with its hand-written result. A row whose result
   // has last clear is checked against the predictor instead.
   typedef struct packed {
      req_type req;
      rsp_type want;
   } plan_row_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   // Predicted route table and the results it still owes.
   logic [31:0] route_net[TABLE_DEPTH];
   logic [31:0] route_msk[TABLE_DEPTH];
   logic [3:0]  route_hops[TABLE_DEPTH];
   logic [31:0] route_src[TABLE_DEPTH];
   int          route_total = 0;
   rsp_type     pending_routes[$];
   plan_row_type directed_plan[$];

   int      send_idle_pct  = 0;
   int      recv_stall_pct = 0;
   int      failures       = 0;
   int      requests_done  = 0;
   int      results_seen   = 0;
   int      status_seen[8] = '{default: 0};
   int      stuck_cycles   = 0;
   rsp_type want_route;

   distance_vector_route_table dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic void owe_route(logic [31:0] net, logic [31:0] msk, logic [4:0] hop,
                                     route_status_type st, logic last);
      rsp_type r;
      r.network    = net;
      r.net_mask   = msk;
      r.hop_metric = hop;
      r.status     = st;
      r.last       = last;
      pending_routes.push_back(r);
   endfunction

   // Search by network, then replace, keep, flag a full table or append.
   function automatic void update_route(logic [31:0] net, logic [31:0] msk, logic [3:0] hop,
                                        logic [31:0] src, bit install);
      int at;
      at = -1;
      for (int i = 0; i < route_total; i++) begin
         if (at < 0 && route_net[i] == net) begin
            at = i;
         end
      end
      if (at >= 0) begin
         if (install || route_hops[at] > hop || route_src[at] == src) begin
            route_msk[at]  = msk;
            route_hops[at] = hop;
            route_src[at]  = src;
            owe_route(net, msk, {1'b0, hop}, ST_REPLACED, 1'b1);
         end else begin
            owe_route(net, route_msk[at], {1'b0, route_hops[at]}, ST_KEPT, 1'b1);
         end
      end else if (route_total >= TABLE_DEPTH) begin
         owe_route(net, msk, {1'b0, hop}, ST_FULL, 1'b1);
      end else begin
         route_net[route_total]  = net;
         route_msk[route_total]  = msk;
         route_hops[route_total] = hop;
         route_src[route_total]  = src;
         route_total++;
         owe_route(net, msk, {1'b0, hop}, ST_ADDED, 1'b1);
      end
   endfunction

   function automatic void predict_routes(req_type r);
      logic [31:0] net;
      int          sent;
      case (op_type'(r.operation))
         OP_LEARN: begin
            if (r.metric > MAX_GOOD_METRIC) begin
               owe_route(r.address, r.mask, METRIC_INFINITY, ST_METRIC_DROP, 1'b1);
            end else if (r.address == LOOPBACK_NET) begin
               owe_route(r.address, r.mask, r.metric[4:0], ST_LOOP_DROP, 1'b1);
            end else begin
               update_route(r.address, r.mask, r.metric[3:0], r.source, 1'b0);
            end
         end
         OP_INSTALL: begin
            net = r.address & r.mask;
            if (net == LOOPBACK_NET) begin
               owe_route(net, r.mask, 5'd0, ST_LOOP_DROP, 1'b1);
            end else begin
               update_route(net, r.mask, 4'd0, LOCAL_SOURCE, 1'b1);
            end
         end
         OP_ADVERTISE: begin
            // Split horizon: routes learned from this interface stay quiet.
            sent = 0;
            for (int i = 0; i < route_total; i++) begin
               if (route_src[i] != r.source) begin
                  owe_route(route_net[i], route_msk[i], {1'b0, route_hops[i]} + 5'd1,
                            ST_ADVERTISED, 1'b0);
                  sent++;
               end
            end
            if (sent == 0) begin
               owe_route(32'h0, 32'h0, 5'd0, ST_EMPTY, 1'b1);
            end else begin
               pending_routes[pending_routes.size() - 1].last = 1'b1;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void plan_request(op_type op, logic [31:0] addr, logic [31:0] msk,
                                        logic [31:0] met, logic [31:0] src, rsp_type want);
      plan_row_type row;
      row.req.operation = op;
      row.req.address   = addr;
      row.req.mask      = msk;
      row.req.metric    = met;
      row.req.source    = src;
      row.want          = want;
      directed_plan.push_back(row);
   endfunction

   function automatic logic [31:0] prefix_mask();
      int len;
      len = $urandom_range(32);
      return (len == 0) ? 32'h0 : 32'hFFFF_FFFF << (32 - len);
   endfunction

   function automatic logic [31:0] pick_source();
      case ($urandom_range(4))
         0: return NEIGHBOR_A;
         1: return NEIGHBOR_B;
         2: return NEIGHBOR_C;
         3: return LOCAL_SOURCE;
         default: return $urandom;
      endcase
   endfunction

   function automatic req_type fresh_route();
      req_type r;
      r.operation = OP_LEARN;
      r.address   = $urandom;
      r.mask      = $urandom_range(1) ? prefix_mask() : $urandom;
      r.metric    = $urandom_range(15);
      r.source    = pick_source();
      return r;
   endfunction

   // Mostly well-formed route traffic, with bad metrics, loopback and
   // unused operations mixed in.
   function automatic req_type random_request();
      req_type r;
      int      pick;
      pick = $urandom_range(99);
      r    = fresh_route();
      if (pick < 30) begin
         if (route_total > 0) begin
            r.address = route_net[$urandom_range(route_total - 1)];
         end
      end else if (pick < 50) begin
      end else if (pick < 62) begin
         r.operation = OP_INSTALL;
         r.metric    = $urandom;
         if (route_total > 0 && $urandom_range(1)) begin
            r.address = route_net[$urandom_range(route_total - 1)];
            r.mask    = 32'hFFFF_FFFF;
         end
      end else if (pick < 77) begin
         r.operation = OP_ADVERTISE;
         r.address   = $urandom;
         r.metric    = $urandom;
      end else if (pick < 85) begin
         r.metric = $urandom;
         if (r.metric <= MAX_GOOD_METRIC) begin
            r.metric = r.metric | 32'h8000_0000;
         end
      end else if (pick < 92) begin
         if ($urandom_range(1)) begin
            r.address = LOOPBACK_NET;
         end else begin
            r.operation = OP_INSTALL;
            r.address   = LOOPBACK_NET | ($urandom & 32'h00FF_FFFF);
            r.mask      = 32'hFF00_0000;
         end
      end else begin
         r.operation = OP_UNUSED;
         r.metric    = $urandom;
         r.source    = $urandom;
      end
      return r;
   endfunction

   // Called at a falling edge; returns at the falling edge after acceptance
   // with req_valid still high.
   task automatic send_request(req_type r, rsp_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= r;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      if (want.last) begin
         pending_routes.push_back(want);
      end else begin
         predict_routes(r);
      end
      requests_done++;
      @(negedge clock);
   endtask

   // Result stall, redrawn every cycle.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < recv_stall_pct);
   end

   // Compare each result with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         status_seen[rsp_data.status]++;
         if (pending_routes.size() == 0) begin
            $error("unexpected result: network %h status %0d", rsp_data.network,
                   rsp_data.status);
            failures++;
         end else begin
            want_route = pending_routes.pop_front();
            if (rsp_data.network !== want_route.network) begin
               $error("network: expected %h, got %h", want_route.network, rsp_data.network);
               failures++;
            end
            if (rsp_data.net_mask !== want_route.net_mask) begin
               $error("net_mask: expected %h, got %h", want_route.net_mask, rsp_data.net_mask);
               failures++;
            end
            if (rsp_data.hop_metric !== want_route.hop_metric) begin
               $error("hop_metric: expected %0d, got %0d", want_route.hop_metric,
                      rsp_data.hop_metric);
               failures++;
            end
            if (rsp_data.status !== want_route.status) begin
               $error("status: expected %0d, got %0d", want_route.status, rsp_data.status);
               failures++;
            end
            if (rsp_data.last !== want_route.last) begin
               $error("last: expected %0d, got %0d", want_route.last, rsp_data.last);
               failures++;
            end
         end
      end
   end

   // Give up when neither channel has moved for too long.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            stuck_cycles = 0;
         end else begin
            stuck_cycles++;
         end
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int idle_by_mode[4];
      int stall_by_mode[4];
      idle_by_mode  = '{0, 58, 0, 35};
      stall_by_mode = '{0, 0, 58, 35};

      // Directed requests: drops, loopback, the added, replaced and kept outcomes and
      // split-horizon advertisements.
      plan_request(OP_ADVERTISE, 32'h0, 32'h0, 32'h0, 32'h0,
                   rsp_type'{32'h0, 32'h0, 5'd0, ST_EMPTY, 1'b1});
      plan_request(OP_LEARN, 32'hC0A8_0100, 32'hFFFF_FF00, 32'd16, NEIGHBOR_A,
                   rsp_type'{32'hC0A8_0100, 32'hFFFF_FF00, 5'd16, ST_METRIC_DROP, 1'b1});
      plan_request(OP_LEARN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   rsp_type'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd16, ST_METRIC_DROP, 1'b1});
      plan_request(OP_LEARN, LOOPBACK_NET, 32'hFF00_0000, 32'd15, NEIGHBOR_A,
                   rsp_type'{LOOPBACK_NET, 32'hFF00_0000, 5'd15, ST_LOOP_DROP, 1'b1});
      plan_request(OP_INSTALL, 32'h7F00_0001, 32'hFF00_0000, 32'd7, 32'h0,
                   rsp_type'{LOOPBACK_NET, 32'hFF00_0000, 5'd0, ST_LOOP_DROP, 1'b1});
      plan_request(OP_LEARN, LOOPBACK_NET, 32'hFF00_0000, 32'd16, NEIGHBOR_B,
                   rsp_type'{LOOPBACK_NET, 32'hFF00_0000, 5'd16, ST_METRIC_DROP, 1'b1});
      plan_request(OP_UNUSED, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 32'hFFFF_FFFF, 32'h1234_5678, '0);
      plan_request(OP_INSTALL, 32'h0A01_0203, 32'hFFFF_FF00, 32'h0, 32'h0, '0);
      plan_request(OP_LEARN, 32'h0A01_0200, 32'hFFFF_FF00, 32'd5, NEIGHBOR_A, '0);
      plan_request(OP_LEARN, 32'hC0A8_0000, 32'hFFFF_0000, 32'd15, NEIGHBOR_A, '0);
      plan_request(OP_LEARN, 32'hC0A8_0000, 32'hFFFF_0000, 32'd15, NEIGHBOR_B, '0);
      plan_request(OP_LEARN, 32'hC0A8_0000, 32'hFFFF_FF00, 32'd3, NEIGHBOR_B, '0);
      plan_request(OP_LEARN, 32'hC0A8_0000, 32'hFFFF_0000, 32'd9, NEIGHBOR_B, '0);
      plan_request(OP_LEARN, 32'h0, 32'h0, 32'd0, 32'h0, '0);
      plan_request(OP_LEARN, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd15, 32'hFFFF_FFFF, '0);
      plan_request(OP_LEARN, 32'h0A01_0200, 32'hFFFF_FF80, 32'd0, LOCAL_SOURCE, '0);
      plan_request(OP_LEARN, 32'h7F00_0001, 32'hFFFF_FFFF, 32'd1, NEIGHBOR_C, '0);
      plan_request(OP_ADVERTISE, 32'h0, 32'h0, 32'h0, NEIGHBOR_B, '0);
      plan_request(OP_ADVERTISE, 32'h0, 32'h0, 32'h0, LOCAL_SOURCE, '0);
      plan_request(OP_ADVERTISE, 32'h0, 32'h0, 32'h0, 32'hDEAD_BEEF, '0);
      plan_request(OP_INSTALL, 32'hC0A8_1234, 32'hFFFF_0000, 32'h0, 32'h0, '0);
      plan_request(OP_ADVERTISE, 32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, '0);
      plan_request(OP_INSTALL, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, '0);
      plan_request(OP_ADVERTISE, 32'h0, 32'h0, 32'h0, NEIGHBOR_A, '0);

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_plan[i]) begin
         send_request(directed_plan[i].req, directed_plan[i].want);
      end

      // Random traffic under each idling mode. The last mode also fills the
      // table to its limit and pushes past it.
      for (int mode = 0; mode < 4; mode++) begin
         send_idle_pct  = idle_by_mode[mode];
         recv_stall_pct = stall_by_mode[mode];
         for (int n = 0; n < ITEMS_PER_MODE; n++) begin
            if (mode == 3 && n == 10) begin
               while (route_total < TABLE_DEPTH) begin
                  send_request(fresh_route(), '0);
               end
               send_request(fresh_route(), '0);
               send_request(fresh_route(), '0);
               send_request(random_request(), '0);
            end
            send_request(random_request(), '0);
         end
      end
      req_valid <= 1'b0;

      while (pending_routes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Ran %0d requests, %0d results, table peak %0d of %0d routes.",
               requests_done, results_seen, route_total, TABLE_DEPTH);
      $display("Added %0d, replaced %0d, kept %0d, dropped %0d, full %0d, advertised %0d.",
               status_seen[ST_ADDED], status_seen[ST_REPLACED], status_seen[ST_KEPT],
               status_seen[ST_METRIC_DROP] + status_seen[ST_LOOP_DROP],
               status_seen[ST_FULL], status_seen[ST_ADVERTISED]);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
